// File: rtl/tick_driven_time_of_day_clock_macros.svh
// Assertion macros used by the time-of-day clock RTL.
// No dependencies; expects clk_i and rst_ni in the including module.
`ifndef TICK_DRIVEN_TIME_OF_DAY_CLOCK_MACROS_SVH
`define TICK_DRIVEN_TIME_OF_DAY_CLOCK_MACROS_SVH

// same-cycle implication, idle during reset
`define TDTC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, idle during reset
`define TDTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tdtc_pkg.sv
// Shared constants and types of the time-of-day clock.
// No dependencies.
package tdtc_pkg;

  // tick counter width, fixed by the input word layout
  localparam int unsigned TICK_BITS = 32;
  localparam int unsigned US_W      = 20;  // microsecond field
  localparam int unsigned WK_W      = 20;  // seconds within a week

  localparam logic [US_W-1:0] US_PER_S    = 20'd1000000;
  localparam logic [WK_W-1:0] S_PER_WEEK  = 20'd604800;
  localparam logic [WK_W:0]   S_PER_2WEEK = 21'd1209600;
  localparam logic [16:0]     SEC_PER_DAY = 17'd86400;
  localparam logic [11:0]     SEC_PER_HR  = 12'd3600;
  localparam logic [5:0]      SEC_PER_MIN = 6'd60;
  localparam logic [4:0]      HR_PER_DAY  = 5'd24;

  localparam logic [US_W-1:0] PERIOD_RST = 20'd1000;
  localparam logic [US_W-1:0] PERIOD_MAX = 20'd1000000;

  // reciprocals for constant division; quotient may be one low where noted
  localparam logic [12:0] RCP_SPAN    = 13'd4294;     // floor(2^26/15625), after >>6
  localparam int unsigned RCP_SPAN_SH = 26;
  localparam logic [20:0] RCP_PROD    = 21'd1099511;  // floor(2^34/15625), after >>6
  localparam int unsigned RCP_PROD_SH = 34;
  localparam logic [12:0] RCP_WEEK    = 13'd7101;     // floor(2^25/4725), after >>7
  localparam int unsigned RCP_WEEK_SH = 25;
  // exact reciprocals (rounded up) for the narrow field split
  localparam logic [20:0] RCP_60_S    = 21'd1118482;  // ceil(2^26/60)
  localparam int unsigned RCP_60_S_SH = 26;
  localparam logic [14:0] RCP_60_M    = 15'd17477;    // ceil(2^20/60)
  localparam int unsigned RCP_60_M_SH = 20;
  localparam logic [7:0]  RCP_24      = 8'd171;       // ceil(2^12/24)
  localparam int unsigned RCP_24_SH   = 12;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_SET    = 1'b1;

  localparam int unsigned SCALE_STAGES = 9;
  localparam int unsigned SPLIT_STAGES = 4;

  // clock as seconds of the week plus microseconds
  typedef struct packed {
    logic [WK_W-1:0] week_s;
    logic [US_W-1:0] micro;
  } tod_t;

  // advance worked out from a tick span
  typedef struct packed {
    logic [WK_W-1:0] delta_s;   // whole seconds, mod one week
    logic [US_W-1:0] frac_us;   // microsecond remainder
  } adv_t;

  typedef struct packed {
    logic load;     // an item enters the accumulator stage
    logic is_set;   // that item loads the clock
  } acc_ctrl_t;

endpackage

// File: rtl/tdtc_scale.sv
// Tick span to clock advance: split by 1e6, scale by the period, reduce mod a week.
// Depends on tdtc_pkg.
module tdtc_scale (
  input  logic                                 clk_i,
  input  logic [tdtc_pkg::SCALE_STAGES-1:0]    en_i,
  input  logic [tdtc_pkg::TICK_BITS-1:0]       span_i,
  input  logic [tdtc_pkg::US_W-1:0]            period_i,
  output tdtc_pkg::adv_t                       adv_o
);

  logic [38:0] prod1;
  logic [54:0] prodq;
  logic [37:0] prodg;

  logic [31:0] span1_q;
  logic [12:0] q1_q, q2_q, whole_q;
  logic [20:0] r1_q;
  logic [19:0] part_q;
  logic [39:0] prodp_q, prodp5_q;
  logic [31:0] gsec_q, gsec5_q;
  logic [19:0] qp_q, qp6_q, pq_q, pr_q, pr8_q, pr9_q, gm_q, delta_q;
  logic [12:0] qg_q;
  logic [20:0] rp_q, rg_q, sum_q;

  assign prod1 = 39'(span_i[tdtc_pkg::TICK_BITS-1:6]) * 39'(tdtc_pkg::RCP_SPAN);
  assign prodq = 55'(prodp_q[39:6]) * 55'(tdtc_pkg::RCP_PROD);
  assign prodg = 38'(gsec_q[31:7]) * 38'(tdtc_pkg::RCP_WEEK);

  always_ff @(posedge clk_i) begin
    // span / 1e6, estimate
    if (en_i[0]) begin
      span1_q <= span_i;
      q1_q    <= prod1[tdtc_pkg::RCP_SPAN_SH +: 13];
    end
    if (en_i[1]) begin
      r1_q <= 21'(span1_q - 32'(q1_q) * 32'(tdtc_pkg::US_PER_S));
      q2_q <= q1_q;
    end
    // correct the estimate
    if (en_i[2]) begin
      if (r1_q >= 21'(tdtc_pkg::US_PER_S)) begin
        whole_q <= q2_q + 13'd1;
        part_q  <= 20'(r1_q - 21'(tdtc_pkg::US_PER_S));
      end else begin
        whole_q <= q2_q;
        part_q  <= r1_q[19:0];
      end
    end
    // scale both halves by the period
    if (en_i[3]) begin
      prodp_q <= 40'(part_q) * 40'(period_i);
      gsec_q  <= 32'(whole_q) * 32'(period_i);
    end
    // product / 1e6 and whole seconds / week, estimates
    if (en_i[4]) begin
      qp_q     <= prodq[tdtc_pkg::RCP_PROD_SH +: 20];
      qg_q     <= prodg[tdtc_pkg::RCP_WEEK_SH +: 13];
      prodp5_q <= prodp_q;
      gsec5_q  <= gsec_q;
    end
    if (en_i[5]) begin
      rp_q  <= 21'(prodp5_q - 40'(qp_q) * 40'(tdtc_pkg::US_PER_S));
      rg_q  <= 21'(gsec5_q - 32'(qg_q) * 32'(tdtc_pkg::S_PER_WEEK));
      qp6_q <= qp_q;
    end
    if (en_i[6]) begin
      if (rp_q >= 21'(tdtc_pkg::US_PER_S)) begin
        pq_q <= qp6_q + 20'd1;
        pr_q <= 20'(rp_q - 21'(tdtc_pkg::US_PER_S));
      end else begin
        pq_q <= qp6_q;
        pr_q <= rp_q[19:0];
      end
      gm_q <= (rg_q >= 21'(tdtc_pkg::S_PER_WEEK)) ? 20'(rg_q - 21'(tdtc_pkg::S_PER_WEEK))
                                                  : rg_q[19:0];
    end
    // carried seconds, below three weeks
    if (en_i[7]) begin
      sum_q <= 21'(gm_q) + 21'(pq_q);
      pr8_q <= pr_q;
    end
    if (en_i[8]) begin
      if (sum_q >= tdtc_pkg::S_PER_2WEEK) begin
        delta_q <= 20'(sum_q - tdtc_pkg::S_PER_2WEEK);
      end else if (sum_q >= 21'(tdtc_pkg::S_PER_WEEK)) begin
        delta_q <= 20'(sum_q - 21'(tdtc_pkg::S_PER_WEEK));
      end else begin
        delta_q <= sum_q[19:0];
      end
      pr9_q <= pr8_q;
    end
  end

  assign adv_o.delta_s = delta_q;
  assign adv_o.frac_us = pr9_q;

endmodule

// File: rtl/tdtc_accum.sv
// Clock state: seconds of the week and microseconds, advanced or loaded per word.
// Depends on tdtc_pkg and the assertion macro header.
`include "tick_driven_time_of_day_clock_macros.svh"

module tdtc_accum (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tdtc_pkg::acc_ctrl_t ctrl_i,
  input  tdtc_pkg::adv_t      adv_i,
  input  tdtc_pkg::tod_t      set_i,
  output tdtc_pkg::tod_t      tod_o
);

  logic [tdtc_pkg::WK_W-1:0] week_q, week_d;
  logic [tdtc_pkg::US_W-1:0] micro_q, micro_d;
  logic [tdtc_pkg::US_W:0]   us_sum;
  logic [tdtc_pkg::WK_W:0]   wk0, wk1, wsum;
  logic                      carry;

  always_comb begin
    us_sum = 21'(adv_i.frac_us) + 21'(micro_q);
    carry  = us_sum >= 21'(tdtc_pkg::US_PER_S);
    // both carry outcomes in parallel
    wk0    = 21'(week_q) + 21'(adv_i.delta_s);
    wk1    = wk0 + 21'd1;
    wsum   = carry ? wk1 : wk0;
    if (ctrl_i.is_set) begin
      week_d  = set_i.week_s;
      micro_d = set_i.micro;
    end else begin
      micro_d = carry ? 20'(us_sum - 21'(tdtc_pkg::US_PER_S)) : us_sum[19:0];
      week_d  = (wsum >= 21'(tdtc_pkg::S_PER_WEEK))
              ? 20'(wsum - 21'(tdtc_pkg::S_PER_WEEK)) : wsum[19:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      week_q  <= '0;
      micro_q <= '0;
    end else if (ctrl_i.load) begin
      week_q  <= week_d;
      micro_q <= micro_d;
    end
  end

  assign tod_o.week_s = week_q;
  assign tod_o.micro  = micro_q;

  `TDTC_ASSERT_NOW(a_week_range, 1'b1, week_q < tdtc_pkg::S_PER_WEEK, "week seconds out of range")
  `TDTC_ASSERT_NOW(a_micro_range, 1'b1, micro_q < tdtc_pkg::US_PER_S, "microseconds out of range")
  `TDTC_ASSERT_NEXT(a_hold, !ctrl_i.load, $stable(week_q) && $stable(micro_q), "clock moved idle")

endmodule

// File: rtl/tdtc_split.sv
// Seconds of the week into weekday, hour, minute, second; four stages.
// Depends on tdtc_pkg.
module tdtc_split (
  input  logic                              clk_i,
  input  logic [tdtc_pkg::SPLIT_STAGES-1:0] en_i,
  input  tdtc_pkg::tod_t                    tod_i,
  output logic [2:0]                        weekday_o,
  output logic [4:0]                        hour_o,
  output logic [5:0]                        minute_o,
  output logic [5:0]                        second_o,
  output logic [19:0]                       micro_o
);

  logic [40:0] prod_s;
  logic [28:0] prod_m;
  logic [15:0] prod_d;

  logic [19:0] wk_q;
  logic [13:0] q60_q, mall_q;
  logic [7:0]  hall_q, hall_n_q;
  logic [5:0]  sec_q, sec_n_q, min_q;
  logic [2:0]  wd_q;
  logic [19:0] mic_l_q, mic_m_q, mic_n_q;
  logic [2:0]  weekday_q;
  logic [4:0]  hour_q;
  logic [5:0]  minute_q, second_q;
  logic [19:0] micro_q;

  assign prod_s = 41'(tod_i.week_s) * 41'(tdtc_pkg::RCP_60_S);
  assign prod_m = 29'(q60_q) * 29'(tdtc_pkg::RCP_60_M);
  assign prod_d = 16'(hall_q) * 16'(tdtc_pkg::RCP_24);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      wk_q    <= tod_i.week_s;
      q60_q   <= prod_s[tdtc_pkg::RCP_60_S_SH +: 14];
      mic_l_q <= tod_i.micro;
    end
    if (en_i[1]) begin
      sec_q   <= 6'(wk_q - 20'(q60_q) * 20'(tdtc_pkg::SEC_PER_MIN));
      hall_q  <= prod_m[tdtc_pkg::RCP_60_M_SH +: 8];
      mall_q  <= q60_q;
      mic_m_q <= mic_l_q;
    end
    if (en_i[2]) begin
      min_q    <= 6'(mall_q - 14'(hall_q) * 14'(tdtc_pkg::SEC_PER_MIN));
      wd_q     <= prod_d[tdtc_pkg::RCP_24_SH +: 3];
      hall_n_q <= hall_q;
      sec_n_q  <= sec_q;
      mic_n_q  <= mic_m_q;
    end
    if (en_i[3]) begin
      weekday_q <= wd_q;
      hour_q    <= 5'(hall_n_q - 8'(wd_q) * 8'(tdtc_pkg::HR_PER_DAY));
      minute_q  <= min_q;
      second_q  <= sec_n_q;
      micro_q   <= mic_n_q;
    end
  end

  assign weekday_o = weekday_q;
  assign hour_o    = hour_q;
  assign minute_o  = minute_q;
  assign second_o  = second_q;
  assign micro_o   = micro_q;

endmodule

// File: rtl/tick_driven_time_of_day_clock.sv
// Time-of-day clock with weekday, advanced by a free-running tick counter.
// Usage:
//  - Input stream s_axis_*: one word per command. tuser selects update
//    (read the clock) or set (load every field, clamped to its maximum).
//    Both record the tick count; only an update returns a word.
//  - Output stream m_axis_*: the clock after each update, in order.
//  - cfg_we_i/cfg_wdata_i: tick period in microseconds; write while idle.
//    Zero acts as one, values above one second act as one second.
// Timing: one word per cycle sustained while m_axis_tready is high. The only
//  feedback loop is the seconds-of-week accumulator; with the input stage,
//  nine scaling stages before it and four split stages after it, the block
//  is fifteen pipeline stages in all.
// Stalls: every stage has its own valid bit, so bubbles collapse and words
//  keep entering while a result waits, until the pipeline is full; then
//  s_axis_tready drops with m_axis_tready low.
// Reset: clock, last tick and pipeline valids clear at once; the period
//  returns to 1000 us. No clearing pass, so input is taken right away.
// Depends on tdtc_pkg, tdtc_scale, tdtc_accum and tdtc_split.
module tick_driven_time_of_day_clock (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [19:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // current_tick[31:0], set_weekday[34:32], set_hour[39:35],
  // set_minute[45:40], set_second[51:46], set_micro[71:52]
  input  logic [71:0] s_axis_tdata,
  // opcode[0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // weekday[2:0], hour[7:3], minute[13:8], second[19:14], micro[39:20]
  output logic [39:0] m_axis_tdata
);

  localparam int unsigned NSTG   = 2 + tdtc_pkg::SCALE_STAGES + tdtc_pkg::SPLIT_STAGES;
  localparam int unsigned ST_ACC = 1 + tdtc_pkg::SCALE_STAGES;

  localparam logic [2:0]  MAX_WD  = 3'd6;
  localparam logic [4:0]  MAX_HR  = 5'd23;
  localparam logic [5:0]  MAX_MS  = 6'd59;
  localparam logic [19:0] MAX_US  = 20'd999999;

  logic [NSTG-1:0]  vld_q, vld_d, vld_in, en;
  logic [ST_ACC:0]  set_q, set_d, set_in;
  logic             accept;

  logic [tdtc_pkg::TICK_BITS-1:0] tick, last_tick_q, span0_q;
  logic [tdtc_pkg::US_W-1:0]      period_q;

  // clamped set fields at the input stage
  logic [2:0]  wd_c, wd0_q;
  logic [4:0]  hr_c, hr0_q;
  logic [5:0]  mn_c, mn0_q, sc_c, sc0_q;
  logic [19:0] us_c, us0_q;

  tdtc_pkg::tod_t      set_tod;
  tdtc_pkg::tod_t      set_pipe_q [tdtc_pkg::SCALE_STAGES];
  tdtc_pkg::adv_t      adv;
  tdtc_pkg::tod_t      tod;
  tdtc_pkg::acc_ctrl_t acc_ctrl;

  logic [2:0]  weekday;
  logic [4:0]  hour;
  logic [5:0]  minute, second;
  logic [19:0] micro;

  // stage enables: a stage moves when empty or when its successor moves
  always_comb begin
    en[NSTG-1] = !vld_q[NSTG-1] || m_axis_tready;
    for (int s = NSTG - 2; s >= 0; s--) begin
      en[s] = !vld_q[s] || en[s+1];
    end
  end

  assign s_axis_tready = en[0];
  assign accept        = s_axis_tvalid && en[0];

  // set words stop at the accumulator: nothing to report
  assign vld_in = {vld_q[NSTG-2:ST_ACC+1], vld_q[ST_ACC] & ~set_q[ST_ACC],
                   vld_q[ST_ACC-1:0], s_axis_tvalid};
  assign set_in = {set_q[ST_ACC-1:0], s_axis_tuser[0] == tdtc_pkg::OP_SET};
  assign vld_d  = (en & vld_in) | (~en & vld_q);
  assign set_d  = (en[ST_ACC:0] & set_in) | (~en[ST_ACC:0] & set_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      set_q       <= '0;
      last_tick_q <= '0;
      period_q    <= tdtc_pkg::PERIOD_RST;
    end else begin
      vld_q <= vld_d;
      set_q <= set_d;
      if (accept) begin
        last_tick_q <= tick;
      end
      if (cfg_we_i) begin
        if (cfg_wdata_i == '0) begin
          period_q <= 20'd1;
        end else if (cfg_wdata_i > tdtc_pkg::PERIOD_MAX) begin
          period_q <= tdtc_pkg::PERIOD_MAX;
        end else begin
          period_q <= cfg_wdata_i;
        end
      end
    end
  end

  assign tick = s_axis_tdata[tdtc_pkg::TICK_BITS-1:0];
  assign wd_c = (s_axis_tdata[34:32] > MAX_WD) ? MAX_WD : s_axis_tdata[34:32];
  assign hr_c = (s_axis_tdata[39:35] > MAX_HR) ? MAX_HR : s_axis_tdata[39:35];
  assign mn_c = (s_axis_tdata[45:40] > MAX_MS) ? MAX_MS : s_axis_tdata[45:40];
  assign sc_c = (s_axis_tdata[51:46] > MAX_MS) ? MAX_MS : s_axis_tdata[51:46];
  assign us_c = (s_axis_tdata[71:52] > MAX_US) ? MAX_US : s_axis_tdata[71:52];

  // input stage: modular tick span and clamped set values
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      span0_q <= tick - last_tick_q;
      wd0_q   <= wd_c;
      hr0_q   <= hr_c;
      mn0_q   <= mn_c;
      sc0_q   <= sc_c;
      us0_q   <= us_c;
    end
  end

  // set value as seconds of the week, shift-and-add constants
  assign set_tod.week_s = 20'(wd0_q) * 20'(tdtc_pkg::SEC_PER_DAY)
                        + 20'(hr0_q) * 20'(tdtc_pkg::SEC_PER_HR)
                        + 20'(mn0_q) * 20'(tdtc_pkg::SEC_PER_MIN)
                        + 20'(sc0_q);
  assign set_tod.micro  = us0_q;

  // set values ride alongside the scaling stages
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      set_pipe_q[0] <= set_tod;
    end
    for (int s = 1; s < tdtc_pkg::SCALE_STAGES; s++) begin
      if (en[s+1]) begin
        set_pipe_q[s] <= set_pipe_q[s-1];
      end
    end
  end

  tdtc_scale u_scale (
    .clk_i    (clk_i),
    .en_i     (en[ST_ACC-1:1]),
    .span_i   (span0_q),
    .period_i (period_q),
    .adv_o    (adv)
  );

  assign acc_ctrl.load   = en[ST_ACC] && vld_q[ST_ACC-1];
  assign acc_ctrl.is_set = set_q[ST_ACC-1];

  tdtc_accum u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (acc_ctrl),
    .adv_i  (adv),
    .set_i  (set_pipe_q[tdtc_pkg::SCALE_STAGES-1]),
    .tod_o  (tod)
  );

  tdtc_split u_split (
    .clk_i     (clk_i),
    .en_i      (en[NSTG-1:ST_ACC+1]),
    .tod_i     (tod),
    .weekday_o (weekday),
    .hour_o    (hour),
    .minute_o  (minute),
    .second_o  (second),
    .micro_o   (micro)
  );

  assign m_axis_tvalid = vld_q[NSTG-1];
  assign m_axis_tdata  = {micro, second, minute, hour, weekday};

endmodule
